// ===== hdl/mandelbrot_escape_time_core_defines.svh =====
// Assertion macros used by the escape-time core controller.
`ifndef MANDELBROT_ESCAPE_TIME_CORE_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MET_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/met_pkg.sv =====
// Types, constants and helpers of the escape-time core.
package met_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 27;
  localparam int MAX_SIDE   = 4096;
  localparam int IDX_W      = 12;
  localparam int ITER_W     = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_C_W   = IDX_W + 1 + COORD_BITS;  // index times step
  localparam int SUM_W      = PROD_C_W + 2;            // wide enough for every pre-saturation sum
  localparam int SQ_W       = 2 * COORD_BITS;

  localparam logic signed [COORD_BITS-1:0] TWO_Q27     = COORD_BITS'(64'sd1 <<< (FRAC_BITS + 1));
  localparam logic signed [COORD_BITS-1:0] NEG_TWO_Q27 = -TWO_Q27;
  localparam logic signed [SQ_W:0]         FOUR_Q54    = (SQ_W + 1)'(1) <<< (2 * FRAC_BITS + 2);

  localparam logic [ITER_W-1:0]            MAX_ITERS_RST  = ITER_W'(255);
  localparam logic signed [COORD_BITS-1:0] LEFT_EDGE_RST  = COORD_BITS'(-32'sd268435456);
  localparam logic signed [COORD_BITS-1:0] LOWER_EDGE_RST = COORD_BITS'(-32'sd268435456);
  localparam logic signed [COORD_BITS-1:0] X_STEP_RST     = COORD_BITS'(32'sd524288);
  localparam logic signed [COORD_BITS-1:0] Y_STEP_RST     = COORD_BITS'(32'sd524288);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_ITERS  = 3'd0,
    CFG_LEFT_EDGE  = 3'd1,
    CFG_LOWER_EDGE = 3'd2,
    CFG_X_STEP     = 3'd3,
    CFG_Y_STEP     = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_C_MUL,
    ST_C_ADD,
    ST_IT_MUL,
    ST_IT_SUM,
    ST_IT_UPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0] column;
    logic [IDX_W-1:0] pixel_row;
  } pixel_in_t;

  typedef struct packed {
    logic [ITER_W-1:0] iteration_count;
    logic [IDX_W-1:0]  out_column;
    logic [IDX_W-1:0]  out_row;
  } pixel_out_t;

  typedef struct packed {
    logic [ITER_W-1:0]            max_iters;
    logic signed [COORD_BITS-1:0] left_edge;
    logic signed [COORD_BITS-1:0] lower_edge;
    logic signed [COORD_BITS-1:0] x_step;
    logic signed [COORD_BITS-1:0] y_step;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic c_mul;
    logic c_add;
    logic it_mul;
    logic it_sum;
    logic it_upd;
  } dp_cmd_t;

  typedef struct packed {
    logic iter_done;
    logic escaped;
  } dp_status_t;

  // Clamp a wide signed value into the coordinate range.
  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [SUM_W-1:0] v
  );
    logic fits;
    fits = (v[SUM_W-1:COORD_BITS-1] == '0) || (v[SUM_W-1:COORD_BITS-1] == '1);
    if (fits) begin
      return v[COORD_BITS-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  endfunction

endpackage

// ===== hdl/mandelbrot_escape_time_core.sv =====
// Escape-time core: top level joining config registers, controller and datapath.
//
// Usage: write the registers (max_iters, left_edge, lower_edge, x_step, y_step) through
// cfg_we_i/cfg_addr_i/cfg_wdata_i while the core is idle. Present a pixel on in_data_i
// with start_i; the beat is taken at the edge where start_i is high and busy_o is low.
// The core forms c from the pixel indices, iterates z = z*z + c in Q5.27 and returns
// one result beat: done_o is high for exactly one cycle with result_o holding the
// iteration count and the echoed column and row. The receiver cannot stall; the beat
// is gone after that cycle.
// Each iteration passes through the square, sum and update steps (ST_IT_MUL, ST_IT_SUM,
// ST_IT_UPD) of the datapath; point setup passes through ST_C_MUL and ST_C_ADD. The
// result is given in ST_DONE, entered from ST_IT_MUL when the limit stops the pixel
// and from ST_IT_SUM when it escapes. busy_o stays high until the cycle after done_o,
// so one pixel is in flight at a time and the next is taken only after the last result.
// Reset returns the controller to idle and loads the register reset values.
module mandelbrot_escape_time_core import met_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  start_i,
  input  pixel_in_t             in_data_i,
  output logic                  busy_o,
  output logic                  done_o,
  output pixel_out_t            result_o
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  met_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  met_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  met_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .pix_i    (in_data_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o)
  );

endmodule

// ===== hdl/met_cfg_regs.sv =====
// Configuration register file of the escape-time core.
module met_cfg_regs import met_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_MAX_ITERS:  cfg_d.max_iters  = cfg_wdata_i[ITER_W-1:0];
        CFG_LEFT_EDGE:  cfg_d.left_edge  = cfg_wdata_i[COORD_BITS-1:0];
        CFG_LOWER_EDGE: cfg_d.lower_edge = cfg_wdata_i[COORD_BITS-1:0];
        CFG_X_STEP:     cfg_d.x_step     = cfg_wdata_i[COORD_BITS-1:0];
        CFG_Y_STEP:     cfg_d.y_step     = cfg_wdata_i[COORD_BITS-1:0];
        default:        cfg_d = cfg_q;  // unmapped index: drop
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_iters  <= MAX_ITERS_RST;
      cfg_q.left_edge  <= LEFT_EDGE_RST;
      cfg_q.lower_edge <= LOWER_EDGE_RST;
      cfg_q.x_step     <= X_STEP_RST;
      cfg_q.y_step     <= Y_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/met_dp.sv =====
// Datapath: point setup, z squaring, escape test and z update.
module met_dp import met_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  pixel_in_t  pix_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output pixel_out_t result_o
);

  logic [IDX_W-1:0]             col_q, row_q;
  logic signed [PROD_C_W-1:0]   pcx_q, pcy_q;
  logic signed [COORD_BITS-1:0] cx_q, cy_q, x_q, y_q;
  logic signed [SQ_W-1:0]       xx_q, yy_q, xy_q, diff_q;
  logic                         big_q;
  logic [ITER_W-1:0]            count_q;

  logic [IDX_W-1:0]             col_idx, row_idx;
  logic signed [IDX_W:0]        col_s, row_s;
  logic signed [SQ_W:0]         mag2;
  logic                         big_d;
  logic signed [SUM_W-1:0]      cx_sum, cy_sum, nx_sum, ny_sum;

  assign col_idx = IDX_W'(col_q % MAX_SIDE);
  assign row_idx = IDX_W'(row_q % MAX_SIDE);
  assign col_s   = $signed({1'b0, col_idx});
  assign row_s   = $signed({1'b0, row_idx});

  assign cx_sum = SUM_W'(pcx_q) + SUM_W'(cfg_i.left_edge);
  assign cy_sum = SUM_W'(pcy_q) + SUM_W'(cfg_i.lower_edge);

  // Either component at or beyond 2.0 means escape regardless of the sum.
  assign big_d = (x_q >= TWO_Q27) || (x_q <= NEG_TWO_Q27) ||
                 (y_q >= TWO_Q27) || (y_q <= NEG_TWO_Q27);
  assign mag2  = (SQ_W + 1)'(xx_q) + (SQ_W + 1)'(yy_q);

  // Arithmetic shift of a signed value rounds toward minus infinity.
  assign nx_sum = SUM_W'(diff_q >>> FRAC_BITS) + SUM_W'(cx_q);
  assign ny_sum = SUM_W'(xy_q >>> (FRAC_BITS - 1)) + SUM_W'(cy_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q <= pix_i.column;
      row_q <= pix_i.pixel_row;
    end
    if (cmd_i.c_mul) begin
      pcx_q <= col_s * cfg_i.x_step;
      pcy_q <= row_s * cfg_i.y_step;
    end
    if (cmd_i.c_add) begin
      cx_q <= sat_coord(cx_sum);
      cy_q <= sat_coord(cy_sum);
      x_q  <= '0;
      y_q  <= '0;
    end
    if (cmd_i.it_mul) begin
      xx_q  <= x_q * x_q;
      yy_q  <= y_q * y_q;
      xy_q  <= x_q * y_q;
      big_q <= big_d;
    end
    if (cmd_i.it_sum) begin
      diff_q <= xx_q - yy_q;
    end
    if (cmd_i.it_upd) begin
      x_q <= sat_coord(nx_sum);
      y_q <= sat_coord(ny_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.c_add) begin
      count_q <= '0;
    end else if (cmd_i.it_upd) begin
      count_q <= count_q + ITER_W'(1);
    end
  end

  assign status_o.iter_done = (count_q >= cfg_i.max_iters);
  assign status_o.escaped   = big_q || (mag2 >= FOUR_Q54);

  assign result_o.iteration_count = count_q;
  assign result_o.out_column      = col_q;
  assign result_o.out_row         = row_q;

endmodule

// ===== hdl/met_ctrl.sv =====
// Controller: sequences setup and the iteration loop of one pixel.
module met_ctrl import met_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  `include "mandelbrot_escape_time_core_defines.svh"

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_C_MUL;
      ST_C_MUL:  state_d = ST_C_ADD;
      ST_C_ADD:  state_d = ST_IT_MUL;
      ST_IT_MUL: state_d = status_i.iter_done ? ST_DONE : ST_IT_SUM;
      ST_IT_SUM: state_d = status_i.escaped ? ST_DONE : ST_IT_UPD;
      ST_IT_UPD: state_d = ST_IT_MUL;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_C_MUL:  cmd_o.c_mul  = 1'b1;
      ST_C_ADD:  cmd_o.c_add  = 1'b1;
      ST_IT_MUL: cmd_o.it_mul = 1'b1;
      ST_IT_SUM: cmd_o.it_sum = 1'b1;
      ST_IT_UPD: cmd_o.it_upd = 1'b1;
      ST_DONE:   done_o       = 1'b1;
      default:   busy_o       = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `MET_ASSERT_IMPL(a_cmd_onehot, clk_i, rst_ni, 1'b1, $onehot0(cmd_o), "datapath commands overlap")
  `MET_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o && !done_o, "accepted beat did not start work")
  `MET_ASSERT_NEXT(a_escape_done, clk_i, rst_ni, (state_q == ST_IT_SUM) && status_i.escaped, done_o, "escape did not finish the pixel")
  `MET_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy_o, "core stayed busy after result")

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the Mandelbrot escape-time core with its own escape predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import met_pkg::*;

  typedef struct {
    pixel_in_t   px;
    int unsigned gap;
  } pixel_job_t;

  localparam longint COORD_HI = (64'sd1 <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam longint ESC_RADIUS = 64'sd1 <<< (FRAC_BITS + 1);
  localparam longint ESC_NORM = 64'sd1 <<< (2 * FRAC_BITS + 2);
  localparam int unsigned STALL_LIMIT = 800000;
  localparam int unsigned RANDOM_VIEWS = 32;
  localparam int unsigned VIEW_PIXELS = 49;
  localparam int unsigned MAX_GAP = 13;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  start_i = 1'b0;
  pixel_in_t             in_data_i = '0;
  logic                  busy_o;
  logic                  done_o;
  pixel_out_t            result_o;

  cfg_t        escape_cfg;
  pixel_job_t  pending_pixels[$];
  pixel_out_t  expected_counts[$];
  int unsigned idle_wait = 0;
  int unsigned stall_cycles = 0;
  int unsigned n_accepted = 0;
  int unsigned n_capped = 0;
  int unsigned n_results = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_views = 0;

  mandelbrot_escape_time_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .in_data_i   (in_data_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint clamp_coord(longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  // Iterate z = z*z + c in Q5.27 until escape or the limit.
  function automatic pixel_out_t predict_pixel(pixel_in_t px, cfg_t cfg);
    longint     cx, cy, x, y, xx, yy, nx, ny;
    int unsigned n;
    pixel_out_t r;
    cx = clamp_coord(longint'($signed(cfg.left_edge))
                     + (longint'(px.column) % MAX_SIDE) * longint'($signed(cfg.x_step)));
    cy = clamp_coord(longint'($signed(cfg.lower_edge))
                     + (longint'(px.pixel_row) % MAX_SIDE) * longint'($signed(cfg.y_step)));
    x = 0;
    y = 0;
    n = 0;
    while (n < cfg.max_iters) begin
      if (x >= ESC_RADIUS || -x >= ESC_RADIUS || y >= ESC_RADIUS || -y >= ESC_RADIUS) break;
      xx = x * x;
      yy = y * y;
      if (xx + yy >= ESC_NORM) break;
      nx = clamp_coord(((xx - yy) >>> FRAC_BITS) + cx);
      ny = clamp_coord(((x * y) >>> (FRAC_BITS - 1)) + cy);
      x = nx;
      y = ny;
      n++;
    end
    r.iteration_count = ITER_W'(n);
    r.out_column = px.column;
    r.out_row = px.pixel_row;
    return r;
  endfunction

  // Pixel driver: hold a beat until taken, then space the next one by its gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i   <= 1'b0;
      in_data_i <= '0;
      idle_wait <= 0;
    end else begin
      if (start_i && !busy_o) begin
        expected_counts.push_back(predict_pixel(in_data_i, escape_cfg));
        if (expected_counts[$].iteration_count == escape_cfg.max_iters) n_capped++;
        n_accepted++;
      end
      if (!start_i || !busy_o) begin
        if (pending_pixels.size() != 0 && idle_wait >= pending_pixels[0].gap) begin
          in_data_i <= pending_pixels[0].px;
          start_i   <= 1'b1;
          idle_wait <= 0;
          void'(pending_pixels.pop_front());
        end else begin
          start_i <= 1'b0;
          if (!start_i && !busy_o && pending_pixels.size() != 0) idle_wait <= idle_wait + 1;
        end
      end
    end
  end

  task automatic note_mismatch(string what, pixel_out_t want, pixel_out_t got);
    n_mismatch++;
    if (n_mismatch <= 10) begin
      $display("%t mismatch (%s): expected count %0d col %0d row %0d, got count %0d col %0d row %0d",
               $realtime, what, want.iteration_count, want.out_column, want.out_row,
               got.iteration_count, got.out_column, got.out_row);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    pixel_out_t want;
    string      bad;
    if (rst_ni && done_o) begin
      n_results++;
      if (expected_counts.size() == 0) begin
        note_mismatch("result with nothing pending", '0, result_o);
      end else begin
        want = expected_counts.pop_front();
        bad = "";
        if (result_o.iteration_count !== want.iteration_count) bad = {bad, " count"};
        if (result_o.out_column !== want.out_column) bad = {bad, " column"};
        if (result_o.out_row !== want.out_row) bad = {bad, " row"};
        if (bad != "") note_mismatch({"field", bad}, want, result_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", stall_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_MAX_ITERS:  escape_cfg.max_iters = value[ITER_W-1:0];
      CFG_LEFT_EDGE:  escape_cfg.left_edge = value;
      CFG_LOWER_EDGE: escape_cfg.lower_edge = value;
      CFG_X_STEP:     escape_cfg.x_step = value;
      CFG_Y_STEP:     escape_cfg.y_step = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Upper bits of the limit word carry noise; the core must drop them.
  task automatic apply_view(cfg_t c);
    write_reg(CFG_MAX_ITERS, {16'($urandom), c.max_iters});
    write_reg(CFG_LEFT_EDGE, c.left_edge);
    write_reg(CFG_LOWER_EDGE, c.lower_edge);
    write_reg(CFG_X_STEP, c.x_step);
    write_reg(CFG_Y_STEP, c.y_step);
    n_views++;
  endtask

  task automatic queue_pixel(int unsigned col, int unsigned row, int unsigned gap);
    pixel_job_t j;
    j.px.column = IDX_W'(col);
    j.px.pixel_row = IDX_W'(row);
    j.gap = gap;
    pending_pixels.push_back(j);
  endtask

  // Wait until every queued pixel has been taken and answered, then let the core settle.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || start_i || expected_counts.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic cfg_t random_view();
    cfg_t        c;
    int unsigned mag;
    if ($urandom_range(0, 4) == 0) begin
      c.max_iters  = ITER_W'($urandom_range(0, 40));
      c.left_edge  = $urandom;
      c.lower_edge = $urandom;
      c.x_step     = $urandom;
      c.y_step     = $urandom;
    end else begin
      c.max_iters = ($urandom_range(0, 7) == 0) ? ITER_W'($urandom_range(100, 300))
                                                : ITER_W'($urandom_range(1, 64));
      // window around the set: real -2.5..0.5, imaginary -1.5..1.5
      c.left_edge  = $urandom_range(0, 3 << 27) - (5 << 26);
      c.lower_edge = $urandom_range(0, 3 << 27) - (3 << 26);
      mag = $urandom_range(1 << 8, 1 << 17);
      c.x_step = ($urandom_range(0, 7) == 0) ? -mag : mag;
      mag = $urandom_range(1 << 8, 1 << 17);
      c.y_step = ($urandom_range(0, 7) == 0) ? -mag : mag;
    end
    return c;
  endfunction

  initial begin
    cfg_t view;
    logic burst;
    escape_cfg = '{max_iters: MAX_ITERS_RST, left_edge: LEFT_EDGE_RST,
                   lower_edge: LOWER_EDGE_RST, x_step: X_STEP_RST, y_step: Y_STEP_RST};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset view: corners, points inside the set, the cusp and the c = -2 tip.
    queue_pixel(0, 0, 0);
    queue_pixel(4095, 4095, 0);
    queue_pixel(0, 4095, 3);
    queue_pixel(4095, 0, 0);
    queue_pixel(512, 512, 7);
    queue_pixel(256, 512, 0);
    queue_pixel(448, 512, 1);
    queue_pixel(576, 512, 13);
    queue_pixel(577, 512, 0);
    queue_pixel(0, 512, 2);
    queue_pixel(2730, 1365, 0);
    drain();

    // Zero limit.
    view = escape_cfg;
    view.max_iters = '0;
    apply_view(view);
    queue_pixel(0, 0, 0);
    queue_pixel(512, 512, 0);
    queue_pixel(4095, 4095, 5);
    drain();

    // Coordinate overflow toward both rails.
    view = '{max_iters: 16'd20, left_edge: 32'h7FFF_FFFF, lower_edge: 32'h8000_0000,
             x_step: 32'h7FFF_FFFF, y_step: 32'h8000_0000};
    apply_view(view);
    queue_pixel(4095, 4095, 0);
    queue_pixel(1, 1, 0);
    queue_pixel(0, 0, 4);
    drain();
    view = '{max_iters: 16'd20, left_edge: 32'h8000_0000, lower_edge: 32'h7FFF_FFFF,
             x_step: 32'h8000_0000, y_step: 32'h7FFF_FFFF};
    apply_view(view);
    queue_pixel(4095, 4095, 0);
    queue_pixel(2, 3, 0);
    drain();

    // Full limit at the origin: never escapes.
    view = '{max_iters: 16'hFFFF, left_edge: '0, lower_edge: '0, x_step: '0, y_step: '0};
    apply_view(view);
    queue_pixel(1234, 2345, 0);
    drain();

    for (int v = 0; v < RANDOM_VIEWS; v++) begin
      apply_view(random_view());
      burst = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < VIEW_PIXELS; i++) begin
        queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                    burst ? 0 : $urandom_range(0, MAX_GAP));
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("Checked %0d of %0d pixels over %0d register settings plus reset values",
             n_results, n_accepted, n_views);
    $display("%0d pixels ran to the limit, %0d escaped, %0d mismatches",
             n_capped, n_accepted - n_capped, n_mismatch);
    if (n_mismatch == 0 && expected_counts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/met_pkg.sv
hdl/met_cfg_regs.sv
hdl/met_dp.sv
hdl/met_ctrl.sv
hdl/mandelbrot_escape_time_core.sv
test/tb.sv
